// ----- sv/slbs_pkg.sv -----
`default_nettype none

package slbs_pkg;

   // Register map: word index of each configuration register.
   localparam logic [2:0] REG_REPEAT_COUNT  = 3'd0;
   localparam logic [2:0] REG_ON_TIME_OK    = 3'd1;
   localparam logic [2:0] REG_ON_TIME_ERROR = 3'd2;
   localparam logic [2:0] REG_PERIOD_NEXT   = 3'd3;
   localparam logic [2:0] REG_COMM_WINDOW   = 3'd4;

   localparam int ADDR_BITS = 5;

   // Reset values of the configuration registers.
   localparam logic [7:0]  RESET_REPEAT_COUNT  = 8'd0;
   localparam logic [15:0] RESET_ON_TIME_OK    = 16'd1000;
   localparam logic [15:0] RESET_ON_TIME_ERROR = 16'd50;
   localparam logic [15:0] RESET_PERIOD_NEXT   = 16'd1000;
   localparam logic [15:0] RESET_COMM_WINDOW   = 16'd1000;

   typedef struct packed {
      logic [7:0]  repeat_count;
      logic [15:0] on_time_ok;
      logic [15:0] on_time_error;
      logic [15:0] period_next;
      logic [15:0] comm_window;
   } cfg_type;

endpackage

`default_nettype wire

// ----- sv/slbs_csr.sv -----
`default_nettype none

module slbs_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [slbs_pkg::ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic      [31:0]                     csr_prdata,
   output logic                                 csr_pready,
   output slbs_pkg::cfg_type                    cfg
);

   slbs_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [2:0]        reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_index  = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_count  <= slbs_pkg::RESET_REPEAT_COUNT;
         cfg_ff.on_time_ok    <= slbs_pkg::RESET_ON_TIME_OK;
         cfg_ff.on_time_error <= slbs_pkg::RESET_ON_TIME_ERROR;
         cfg_ff.period_next   <= slbs_pkg::RESET_PERIOD_NEXT;
         cfg_ff.comm_window   <= slbs_pkg::RESET_COMM_WINDOW;
      end else if (wr_en) begin
         unique case (reg_index)
            slbs_pkg::REG_REPEAT_COUNT:  cfg_ff.repeat_count  <= csr_pwdata[7:0];
            slbs_pkg::REG_ON_TIME_OK:    cfg_ff.on_time_ok    <= csr_pwdata[15:0];
            slbs_pkg::REG_ON_TIME_ERROR: cfg_ff.on_time_error <= csr_pwdata[15:0];
            slbs_pkg::REG_PERIOD_NEXT:   cfg_ff.period_next   <= csr_pwdata[15:0];
            slbs_pkg::REG_COMM_WINDOW:   cfg_ff.comm_window   <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         slbs_pkg::REG_REPEAT_COUNT:  csr_prdata = {24'd0, cfg_ff.repeat_count};
         slbs_pkg::REG_ON_TIME_OK:    csr_prdata = {16'd0, cfg_ff.on_time_ok};
         slbs_pkg::REG_ON_TIME_ERROR: csr_prdata = {16'd0, cfg_ff.on_time_error};
         slbs_pkg::REG_PERIOD_NEXT:   csr_prdata = {16'd0, cfg_ff.period_next};
         slbs_pkg::REG_COMM_WINDOW:   csr_prdata = {16'd0, cfg_ff.comm_window};
         default:                     csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/slbs_core.sv -----
`default_nettype none

module slbs_core #(
   parameter int TIMER_BITS = 16,
   parameter int COUNT_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire slbs_pkg::cfg_type cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [15:0]       in_rx_count,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic                   out_led,
   output logic                   out_link_alive
);

   localparam int TCMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam int CCMP_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_LIGHT = 3'd1,
      PH_ON    = 3'd2,
      PH_OFF   = 3'd3,
      PH_PAUSE = 3'd4
   } phase_type;

   phase_type               phase_ff, phase_in, phase_cur;
   logic [COUNT_BITS-1:0]   blink_ff, blink_in, blink_inc;
   logic [TIMER_BITS-1:0]   ptimer_ff, ptimer_in, ptimer_inc;
   logic [TIMER_BITS-1:0]   wtimer_ff, wtimer_in, wtimer_inc;
   logic                    alive_ff, alive_in;
   logic [15:0]             prev_rx_ff, prev_rx_in;
   logic [15:0]             latched_ff, latched_in;
   logic                    led_ff, led_in;
   logic                    out_valid_ff;
   logic                    accept;
   logic                    window_hit;
   logic                    restart;
   logic                    phase_done;
   logic [15:0]             on_time;
   logic [15:0]             pause;
   logic [15:0]             phase_len;
   logic [TCMP_BITS-1:0]    ptimer_cmp;

   assign in_ready       = !out_valid_ff || out_ready;
   assign accept         = in_valid && in_ready;
   assign out_valid      = out_valid_ff;
   assign out_led        = led_ff;
   assign out_link_alive = alive_ff;

   always_comb begin
      ptimer_inc = (ptimer_ff == '1) ? ptimer_ff : ptimer_ff + 1'b1;
      wtimer_inc = (wtimer_ff == '1) ? wtimer_ff : wtimer_ff + 1'b1;
      blink_inc  = (blink_ff == '1) ? blink_ff : blink_ff + 1'b1;

      // Link activity check at the end of each window.
      window_hit = TCMP_BITS'(wtimer_inc) > TCMP_BITS'(cfg.comm_window);
      if (window_hit) begin
         wtimer_in  = '0;
         alive_in   = prev_rx_ff != in_rx_count;
         prev_rx_in = in_rx_count;
      end else begin
         wtimer_in  = wtimer_inc;
         alive_in   = alive_ff;
         prev_rx_in = prev_rx_ff;
      end

      on_time = alive_in ? cfg.on_time_ok : cfg.on_time_error;
      pause   = (cfg.period_next > on_time) ? cfg.period_next - on_time : 16'd0;

      // A new blink time restarts the pattern, but never mid-blink.
      restart    = (latched_ff != on_time) && (phase_ff >= PH_OFF);
      latched_in = restart ? on_time : latched_ff;
      phase_cur  = restart ? PH_START : phase_ff;

      phase_len  = (phase_cur == PH_PAUSE) ? pause : on_time;
      ptimer_cmp = TCMP_BITS'(ptimer_inc);
      phase_done = ptimer_cmp > TCMP_BITS'(phase_len);

      phase_in  = phase_cur;
      blink_in  = blink_ff;
      ptimer_in = ptimer_inc;
      led_in    = led_ff;

      unique case (phase_cur)
         PH_START: begin
            blink_in = '0;
            phase_in = PH_LIGHT;
         end
         PH_LIGHT: begin
            led_in    = 1'b1;
            ptimer_in = '0;
            phase_in  = PH_ON;
         end
         PH_ON: begin
            if (phase_done) begin
               led_in    = 1'b0;
               ptimer_in = '0;
               phase_in  = PH_OFF;
            end
         end
         PH_OFF: begin
            if (phase_done) begin
               ptimer_in = '0;
               if (cfg.repeat_count == 8'd0) begin
                  phase_in = PH_LIGHT;
               end else if (CCMP_BITS'(blink_inc) >= CCMP_BITS'(cfg.repeat_count)) begin
                  blink_in = '0;
                  phase_in = PH_PAUSE;
               end else begin
                  blink_in = blink_inc;
                  phase_in = PH_LIGHT;
               end
            end
         end
         PH_PAUSE: begin
            if (phase_done) begin
               ptimer_in = '0;
               phase_in  = PH_LIGHT;
            end
         end
         default: begin
            phase_in = PH_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         blink_ff     <= '0;
         ptimer_ff    <= '0;
         wtimer_ff    <= '0;
         alive_ff     <= 1'b0;
         prev_rx_ff   <= '0;
         latched_ff   <= '0;
         led_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            blink_ff   <= blink_in;
            ptimer_ff  <= ptimer_in;
            wtimer_ff  <= wtimer_in;
            alive_ff   <= alive_in;
            prev_rx_ff <= prev_rx_in;
            latched_ff <= latched_in;
            led_ff     <= led_in;
         end
         if (accept) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // The LED is lit throughout the on phase.
   a_led_on: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ON) |-> led_ff)
      else $error("LED dark during on phase");

   // The LED is dark throughout the off and pause phases.
   a_led_off: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_OFF || phase_ff == PH_PAUSE) |-> !led_ff)
      else $error("LED lit during off or pause phase");

   // Lighting always leads to the on phase with a fresh timer.
   a_light_to_on: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_LIGHT) |=> (phase_ff == PH_ON && ptimer_ff == '0))
      else $error("light phase did not enter on phase with cleared timer");

   // No result is pending straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("result pending after reset");

endmodule

`default_nettype wire

// ----- sv/status_led_blink_sequencer_unit.sv -----
// Status LED blink sequencer: one tick item in, one LED/link result item out.
// The result of an item is presented in the cycle after it is accepted.
// Throughput: one item per cycle while rsp_tready stays high; the single state update stage is the only loop.
// Reset (synchronous, active high) restores the default registers, the start phase,
// cleared timers and counters, a dark LED, a silent link and an empty result slot.
`default_nettype none

module status_led_blink_sequencer_unit #(
   parameter int TIMER_BITS = 16,
   parameter int COUNT_BITS = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   // Tick items carrying the received-frame count.
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [15:0]                    req_tdata,   // [15:0] rx_count

   // Result items.
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [7:0]                     rsp_tdata,   // [0] led, [1] link_alive, rest zero

   // Register access port.
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [slbs_pkg::ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready
);

   // Configuration registers; the user must write them only while the sequencer is idle, the block does not enforce it.
   slbs_pkg::cfg_type cfg;
   logic              led;
   logic              link_alive;

   slbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The core updates the timers, the link check and the blink phase once per
   // accepted item. Its state registers double as the result register, and a
   // new item is taken whenever the result slot is empty or being emptied.
   slbs_core #(
      .TIMER_BITS (TIMER_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_rx_count    (req_tdata),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_led        (led),
      .out_link_alive (link_alive)
   );

   // Pack the result fields from the lowest bit upwards.
   assign rsp_tdata = {6'd0, link_alive, led};

endmodule

`default_nettype wire
